// ----- rtl/bvr_pkg.sv -----
`timescale 1ns / 1ps

package bvr_pkg;

  // Storage geometry: a word holds 2**OFF_W bits
  localparam int OFF_W     = 6;
  localparam int WORD_BITS = 1 << OFF_W;
  localparam int NUM_WORDS = 64;
  localparam int IDX_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  // Field widths
  localparam int CMD_W = 3;
  localparam int POS_W = 12;
  localparam int LEN_W = 13;
  localparam int PC_W  = OFF_W + 1;

  // Largest length, limited so it fits LEN_W bits
  localparam int MAX_LEN  = 4096;
  localparam int CAPACITY = (WORD_BITS * NUM_WORDS > MAX_LEN) ? MAX_LEN
                                                               : WORD_BITS * NUM_WORDS;

  // Stream word widths
  localparam int IN_FIELDS_W  = CMD_W + POS_W + 1;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + LEN_W + LEN_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_SET    = 3'd1,
    CMD_GET    = 3'd2,
    CMD_RANK   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

endpackage

// ----- rtl/bvr_ram.sv -----
`timescale 1ns / 1ps

module bvr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/bit_vector_rank.sv -----
`timescale 1ns / 1ps

// Growable bit vector of up to CAPACITY bits held in a 64 x 64-bit word
// memory, with append, set, get, rank (ones at positions 0..position) and
// clear commands. One command word is taken at a time and gives exactly one
// result word. Append, set and get read their word and then write or test
// it; append of the first bit of a word skips the read. Rank reads words
// 0 through the word of the position one per cycle through the single
// memory read port, and a registered popcount feeds the accumulator. A
// result that the output cannot take yet holds the block in its done state.
// The memory needs no clearing after reset, since a word is zeroed when its
// first bit is appended. A new command word is taken while a result still
// waits on the output.
module bit_vector_rank
  import bvr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [2:0] cmd, [14:3] position, [15] bit_value
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] bit_out, [13:1] rank_count, [26:14] length_out, [27] error, rest zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MODIFY,
    ST_RANK,
    ST_DONE
  } state_t;

  state_t               state;
  cmd_t                 cur_cmd;
  logic [POS_W-1:0]     cur_pos;
  logic                 cur_bit;
  logic [LEN_W-1:0]     length;

  // Rank pipeline: issue, memory data, popcount register
  logic                 issuing;
  logic [IDX_W-1:0]     raddr;
  logic                 s1_valid;
  logic                 s1_last;
  logic                 s2_valid;
  logic                 s2_last;
  logic [PC_W-1:0]      pc_reg;
  logic [LEN_W-1:0]     acc;

  logic                 res_bit;
  logic [LEN_W-1:0]     res_rank;
  logic                 res_err;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  logic [IDX_W-1:0]     widx;
  logic [OFF_W-1:0]     boff;
  logic [IDX_W-1:0]     aw;
  logic [OFF_W-1:0]     ab;
  logic                 in_range;
  logic                 full;
  logic [WORD_BITS-1:0] pos_sel;
  logic [WORD_BITS-1:0] app_sel;
  logic [WORD_BITS-1:0] last_mask;
  logic [WORD_BITS-1:0] pc_in;
  logic [LEN_W-1:0]     acc_sum;

  bvr_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Decode position and append point
  assign widx      = IDX_W'(cur_pos >> OFF_W);
  assign boff      = cur_pos[OFF_W-1:0];
  assign aw        = IDX_W'(length >> OFF_W);
  assign ab        = length[OFF_W-1:0];
  assign in_range  = {1'b0, cur_pos} < length;
  assign full      = length >= LEN_W'(CAPACITY);
  assign pos_sel   = WORD_BITS'(1) << boff;
  assign app_sel   = WORD_BITS'(1) << ab;
  assign last_mask = {WORD_BITS{1'b1}} >> (OFF_W'(WORD_BITS - 1) - boff);

  // Popcount tree over the word on the read port, last word masked
  assign pc_in = s1_last ? (ram_rdata & last_mask) : ram_rdata;

  wire [WORD_BITS-1:0] pc_lvl [0:OFF_W];
  assign pc_lvl[0] = pc_in;

  for (genvar l = 0; l < OFF_W; l++) begin : g_pc_lvl
    localparam int F  = 1 << l;
    localparam int F2 = 2 * F;
    for (genvar k = 0; k < WORD_BITS / F2; k++) begin : g_pc_pair
      assign pc_lvl[l+1][F2*k +: F2] = F2'(pc_lvl[l][F2*k +: F]) +
                                       F2'(pc_lvl[l][F2*k+F +: F]);
    end
  end

  assign acc_sum = acc + LEN_W'(pc_reg);

  // Memory port control; writes happen only for the current command
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = aw;
    ram_wdata = ram_rdata;
    ram_raddr = raddr;
    unique case (state)
      ST_EXEC: begin
        ram_raddr = (cur_cmd == CMD_APPEND) ? aw : widx;
        // Fresh word on a word boundary: write without reading
        if (cur_cmd == CMD_APPEND && !full && ab == '0) begin
          ram_we    = 1'b1;
          ram_waddr = aw;
          ram_wdata = WORD_BITS'(cur_bit);
        end
      end
      ST_MODIFY: begin
        if (cur_cmd == CMD_APPEND) begin
          ram_we    = 1'b1;
          ram_waddr = aw;
          ram_wdata = cur_bit ? (ram_rdata | app_sel) : ram_rdata;
        end else if (cur_cmd == CMD_SET) begin
          ram_we    = 1'b1;
          ram_waddr = widx;
          ram_wdata = cur_bit ? (ram_rdata | pos_sel) : (ram_rdata & ~pos_sel);
        end
      end
      default: begin
        ram_raddr = raddr;
      end
    endcase
  end

  assign s_axis_tready = (state == ST_IDLE);

  // Command sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      length        <= '0;
      issuing       <= 1'b0;
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // Drop the result once taken; in done a new result takes its place
      if (m_axis_tvalid && m_axis_tready && state != ST_DONE) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            cur_cmd  <= cmd_t'(s_axis_tdata[CMD_W-1:0]);
            cur_pos  <= s_axis_tdata[CMD_W +: POS_W];
            cur_bit  <= s_axis_tdata[CMD_W + POS_W];
            res_bit  <= 1'b0;
            res_rank <= '0;
            res_err  <= 1'b0;
            state    <= ST_EXEC;
          end
        end

        ST_EXEC: begin
          case (cur_cmd) inside
            CMD_APPEND: begin
              if (full) begin
                res_err <= 1'b1;
                state   <= ST_DONE;
              end else if (ab == '0) begin
                length <= length + 1'b1;
                state  <= ST_DONE;
              end else begin
                state <= ST_MODIFY;
              end
            end
            CMD_SET, CMD_GET: begin
              if (!in_range) begin
                res_err <= 1'b1;
                state   <= ST_DONE;
              end else begin
                state <= ST_MODIFY;
              end
            end
            CMD_RANK: begin
              if (!in_range) begin
                res_err <= 1'b1;
                state   <= ST_DONE;
              end else begin
                issuing  <= 1'b1;
                raddr    <= '0;
                acc      <= '0;
                s1_valid <= 1'b0;
                s2_valid <= 1'b0;
                state    <= ST_RANK;
              end
            end
            CMD_CLEAR: begin
              length <= '0;
              state  <= ST_DONE;
            end
            default: begin
              state <= ST_DONE;
            end
          endcase
        end

        ST_MODIFY: begin
          if (cur_cmd == CMD_APPEND) begin
            length <= length + 1'b1;
          end
          if (cur_cmd == CMD_GET) begin
            res_bit <= ram_rdata[boff];
          end
          state <= ST_DONE;
        end

        ST_RANK: begin
          // Issue one word read per cycle up to the word of the position
          if (issuing) begin
            if (raddr == widx) begin
              issuing <= 1'b0;
            end else begin
              raddr <= raddr + 1'b1;
            end
          end
          s1_valid <= issuing;
          s1_last  <= issuing && (raddr == widx);
          // Register the popcount of the word now on the read port
          s2_valid <= s1_valid;
          s2_last  <= s1_last;
          pc_reg   <= pc_lvl[OFF_W][PC_W-1:0];
          // Accumulate, finish on the last word
          if (s2_valid) begin
            acc <= acc_sum;
            if (s2_last) begin
              res_rank <= acc_sum;
              s1_valid <= 1'b0;
              s2_valid <= 1'b0;
              state    <= ST_DONE;
            end
          end
        end

        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {(OUT_TDATA_W - OUT_FIELDS_W)'(0), res_err, length,
                              res_rank, res_bit};
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Length never passes the capacity
  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    length <= LEN_W'(CAPACITY))
    else $error("length beyond capacity");

  // The memory is written only while a command is being applied
  a_we_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_EXEC || state == ST_MODIFY))
    else $error("memory write outside command execution");

  // A finished result waits while the output slot is still taken
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && m_axis_tvalid && !m_axis_tready) |=> state == ST_DONE)
    else $error("result loaded over a pending word");

  // An append that reads its word grows the length by one
  a_app_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MODIFY && cur_cmd == CMD_APPEND) |=> length == $past(length) + 1'b1)
    else $error("append did not advance length");

  // An error result carries no bit and no count
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && res_err) |-> (res_bit == 1'b0 && res_rank == '0))
    else $error("error result with payload");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import bvr_pkg::*;

  localparam logic [CMD_W-1:0] CMD_FIRST_SPARE = 3'd5;
  localparam logic [CMD_W-1:0] CMD_LAST_SPARE  = 3'd7;
  localparam int               DRAIN_CYCLES    = 100;

  typedef struct {
    logic             bit_out;
    logic [LEN_W-1:0] rank_count;
    logic [LEN_W-1:0] length_out;
    logic             error;
  } vec_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Shadow copy of the vector, updated as each command word is accepted
  logic [WORD_BITS-1:0] bv_words [NUM_WORDS];
  int                   bv_len = 0;
  vec_result_t          pending_results[$];
  int                   mismatches = 0;

  // Sender burst state and receiver stall state
  int tx_burst_left = 0;
  bit tx_steady     = 1'b0;
  int rx_hold_left  = 0;
  int rx_mode       = 0;
  int rx_mode_left  = 0;
  logic [7:0] rx_pattern = 8'b1011_0010;

  bit_vector_rank u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Apply one command to the shadow vector and return the result it must give
  function automatic vec_result_t apply_command(logic [CMD_W-1:0] op, logic [POS_W-1:0] pos,
                                                logic val);
    vec_result_t res;
    int          widx;
    int          boff;
    int          total;
    bit          in_range;
    res      = '{default: '0};
    widx     = pos / WORD_BITS;
    boff     = pos % WORD_BITS;
    in_range = (pos < bv_len) && (widx < NUM_WORDS);
    case (op)
      CMD_APPEND: begin
        if (bv_len >= CAPACITY) begin
          res.error = 1'b1;
        end else begin
          if (bv_len % WORD_BITS == 0) bv_words[bv_len / WORD_BITS] = '0;
          bv_words[bv_len / WORD_BITS][bv_len % WORD_BITS] |= val;
          bv_len++;
        end
      end
      CMD_SET: begin
        if (!in_range) res.error = 1'b1;
        else bv_words[widx][boff] = val;
      end
      CMD_GET: begin
        if (!in_range) res.error = 1'b1;
        else res.bit_out = bv_words[widx][boff];
      end
      CMD_RANK: begin
        if (!in_range) begin
          res.error = 1'b1;
        end else begin
          total = 0;
          for (int i = 0; i < widx; i++) total += $countones(bv_words[i]);
          total += $countones(bv_words[widx] & ({WORD_BITS{1'b1}} >> (WORD_BITS - 1 - boff)));
          res.rank_count = LEN_W'(total);
        end
      end
      CMD_CLEAR: bv_len = 0;
      default: ;
    endcase
    res.length_out = LEN_W'(bv_len);
    return res;
  endfunction

  // Queue the expected result of an accepted command word
  function automatic void expect_result(vec_result_t res);
    pending_results = {pending_results, res};
  endfunction

  // Offer one command word; a burst ends with a random gap unless steady
  task automatic send_cmd(logic [CMD_W-1:0] op, logic [POS_W-1:0] pos, logic val);
    int gap;
    if (tx_burst_left == 0) begin
      gap = tx_steady ? 0 : $urandom_range(8, 0);
      if (gap > 0) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      tx_burst_left = $urandom_range(16, 1);
    end
    tx_burst_left--;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {val, pos, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expect_result(apply_command(op, pos, val));
  endtask

  // Mostly a position inside the vector, leaning on both ends
  function automatic logic [POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(9, 0);
    if (bv_len == 0) return POS_W'($urandom_range(4095, 0));
    if (r < 2) return POS_W'(bv_len - 1);
    if (r == 2) return '0;
    return POS_W'($urandom_range(bv_len - 1, 0));
  endfunction

  task automatic note_mismatch(string what, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch in %s: expected %0d, got %0d", what, want, got);
    end
  endtask

  // Compare each result word with the oldest expected one
  always @(posedge clk) begin
    vec_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result word with nothing expected: %h", m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        note_mismatch("bit_out", want.bit_out, m_axis_tdata[0]);
        note_mismatch("rank_count", want.rank_count, m_axis_tdata[13:1]);
        note_mismatch("length_out", want.length_out, m_axis_tdata[26:14]);
        note_mismatch("error", want.error, m_axis_tdata[27]);
        note_mismatch("padding", '0, m_axis_tdata[OUT_TDATA_W-1:OUT_FIELDS_W]);
      end
    end
  end

  // Receiver: forced hold first, then a mode that changes now and then
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_left--;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(3, 0);
        rx_mode_left = $urandom_range(300, 20);
      end
      rx_mode_left--;
      rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(9, 0) < 7);
        2: m_axis_tready <= ($urandom_range(9, 0) < 3);
        default: m_axis_tready <= rx_pattern[0];
      endcase
    end
  end

  // Commands on an empty vector: all position commands fail, spare codes pass
  task automatic test_empty_vector();
    send_cmd(CMD_GET, 12'd0, 1'b0);
    send_cmd(CMD_RANK, 12'd0, 1'b0);
    send_cmd(CMD_SET, 12'd4095, 1'b1);
    for (int c = CMD_FIRST_SPARE; c <= CMD_LAST_SPARE; c++) send_cmd(CMD_W'(c), 12'hfff, 1'b1);
    send_cmd(CMD_CLEAR, 12'd0, 1'b0);
  endtask

  // Short vector: write, read, count, range edge, clear and re-append
  task automatic test_basic_ops();
    send_cmd(CMD_APPEND, 12'd0, 1'b0);
    send_cmd(CMD_APPEND, 12'd0, 1'b1);
    send_cmd(CMD_GET, 12'd0, 1'b0);
    send_cmd(CMD_GET, 12'd1, 1'b0);
    send_cmd(CMD_RANK, 12'd1, 1'b0);
    send_cmd(CMD_SET, 12'd0, 1'b1);
    send_cmd(CMD_RANK, 12'd1, 1'b0);
    send_cmd(CMD_SET, 12'd1, 1'b0);
    send_cmd(CMD_RANK, 12'd0, 1'b0);
    send_cmd(CMD_GET, 12'd2, 1'b0);
    send_cmd(CMD_CLEAR, 12'd0, 1'b0);
    send_cmd(CMD_GET, 12'd0, 1'b0);
    send_cmd(CMD_APPEND, 12'd0, 1'b0);
    send_cmd(CMD_GET, 12'd0, 1'b0);
  endtask

  // Stall the output for a long stretch while commands keep coming
  task automatic test_output_backpressure();
    rx_hold_left = 400;
    tx_steady    = 1'b1;
    for (int i = 0; i < 30; i++) begin
      if (i % 3 == 0) send_cmd(CMD_APPEND, $urandom_range(4095, 0), $urandom_range(1, 0));
      else send_cmd(CMD_GET, pick_position(), 1'b0);
    end
    tx_steady = 1'b0;
  endtask

  // Fill the vector with ones, then probe the full state
  task automatic test_fill_to_capacity();
    send_cmd(CMD_CLEAR, 12'd0, 1'b0);
    for (int i = 0; i < CAPACITY; i++) send_cmd(CMD_APPEND, $urandom_range(4095, 0), 1'b1);
    send_cmd(CMD_APPEND, 12'd0, 1'b0);
    send_cmd(CMD_RANK, 12'd4095, 1'b0);
    send_cmd(CMD_GET, 12'd4095, 1'b0);
    send_cmd(CMD_SET, 12'd4095, 1'b0);
    send_cmd(CMD_RANK, 12'd4095, 1'b0);
    send_cmd(CMD_SET, 12'd2048, 1'b0);
    send_cmd(CMD_RANK, 12'd4094, 1'b0);
    send_cmd(CMD_GET, 12'd2048, 1'b1);
  endtask

  // Mixed traffic, mostly valid positions, some out of range
  task automatic test_random_traffic(int n_items);
    int r;
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0) tx_steady = ($urandom_range(3, 0) == 0);
      r = $urandom_range(99, 0);
      if (r < 2) send_cmd(CMD_CLEAR, $urandom_range(4095, 0), $urandom_range(1, 0));
      else if (r < 3) send_cmd($urandom_range(CMD_LAST_SPARE, CMD_FIRST_SPARE),
                               $urandom_range(4095, 0), $urandom_range(1, 0));
      else if (r < 33) send_cmd(CMD_APPEND, $urandom_range(4095, 0), $urandom_range(1, 0));
      else if (r < 50) send_cmd(CMD_SET, pick_position(), $urandom_range(1, 0));
      else if (r < 70) send_cmd(CMD_GET, pick_position(), $urandom_range(1, 0));
      else if (r < 95) send_cmd(CMD_RANK, pick_position(), $urandom_range(1, 0));
      else if (bv_len < CAPACITY)
        send_cmd($urandom_range(CMD_RANK, CMD_SET), $urandom_range(4095, bv_len),
                 $urandom_range(1, 0));
      else send_cmd(CMD_GET, pick_position(), 1'b1);
    end
    tx_steady = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_vector();
    test_basic_ops();
    test_random_traffic(900);
    test_output_backpressure();
    test_fill_to_capacity();
    test_random_traffic(950);

    // Drop valid, drain, then watch for stray result words
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
